// ----- src/tkt_pkg.sv -----
// Shared types and field widths for the topic key table.
`default_nettype none

package tkt_pkg;

   localparam int FUNC_W  = 2;
   localparam int HASH_W  = 64;
   localparam int KEY_W   = 64;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef struct packed {
      logic hash_we;
      logic key_we;
   } wr_en_type;

endpackage

`default_nettype wire

// ----- src/tkt_req_if.sv -----
// Request channel: operation code and operands with valid/ready.
`default_nettype none

interface tkt_req_if;
   logic                         valid;
   logic                         ready;
   logic [tkt_pkg::FUNC_W-1:0]   func;
   logic [tkt_pkg::HASH_W-1:0]   lookup_hash;
   logic [tkt_pkg::KEY_W-1:0]    new_key;
   logic [tkt_pkg::SLOT_W-1:0]   slot_index;

   modport source (output valid, func, lookup_hash, new_key, slot_index, input ready);
   modport sink   (input valid, func, lookup_hash, new_key, slot_index, output ready);
endinterface

`default_nettype wire

// ----- src/tkt_rsp_if.sv -----
// Response channel: status, slot, key and entry count with valid/ready.
`default_nettype none

interface tkt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [tkt_pkg::SLOT_W-1:0]   found_slot;
   logic [tkt_pkg::KEY_W-1:0]    key_out;
   logic [tkt_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, status, found_slot, key_out, entry_count, input ready);
   modport sink   (input valid, status, found_slot, key_out, entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/tkt_store.sv -----
// Hash and key entry memories: one write port, one registered read port.
`default_nettype none

module tkt_store #(
   parameter int DEPTH     = 64,
   parameter int ADDR_W    = 6,
   parameter int HASH_BITS = 64,
   parameter int KEY_BITS  = 64
) (
   input  wire                    clock,
   input  tkt_pkg::wr_en_type     wr_en,
   input  wire  [ADDR_W-1:0]      wr_addr,
   input  wire  [HASH_BITS-1:0]   wr_hash,
   input  wire  [KEY_BITS-1:0]    wr_key,
   input  wire  [ADDR_W-1:0]      rd_addr,
   output logic [HASH_BITS-1:0]   rd_hash_ff,
   output logic [KEY_BITS-1:0]    rd_key_ff
);

   logic [HASH_BITS-1:0] hash_mem [DEPTH];
   logic [KEY_BITS-1:0]  key_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en.hash_we) begin
         hash_mem[wr_addr] <= wr_hash;
      end
      if (wr_en.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      rd_hash_ff <= hash_mem[rd_addr];
      rd_key_ff  <= key_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/topic_key_table_core.sv -----
// Topic key table top level: request sequencer, entry memories and response register.
`default_nettype none

// The table keeps up to ENTRIES topic-hash/key pairs packed in positions
// 0 to count-1, held in two single-port-write memories with a registered
// read. One request is in work at a time; req ready is high only while the
// sequencer is idle. A set or remove walks the filled entries through the
// one read port, one entry per cycle; a remove then moves each later entry
// up one place, again one entry per cycle, reading entry j while writing
// entry j-1. So a set or remove takes longer the more entries are filled,
// set by the single memory read port. A finished response sits in an output
// register; the next request is taken while it waits, but the following
// response is held until the previous one is taken. There is no clearing
// pass: entries beyond the count are never read.
module topic_key_table_core #(
   parameter int ENTRIES   = 64,
   parameter int HASH_BITS = 64,
   parameter int KEY_BITS  = 64
) (
   input  wire         clock,
   input  wire         reset,
   tkt_req_if.sink     req_chan,
   tkt_rsp_if.source   rsp_chan
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = CNT_W + tkt_pkg::SLOT_W;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SEARCH  = 6'b000010,
      ST_SHIFT   = 6'b000100,
      ST_RD_WAIT = 6'b001000,
      ST_RD_CAPT = 6'b010000,
      ST_RESP    = 6'b100000
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 lag_vld_ff, lag_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // operands and pending result
   tkt_pkg::func_type    func_ff, func_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]     lag_ptr_ff, lag_ptr_in;
   logic                 res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_slot_ff, res_slot_in;
   logic [KEY_BITS-1:0]  res_key_ff, res_key_in;

   // output register
   logic                          rsp_status_ff, rsp_status_in;
   logic [tkt_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [tkt_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [tkt_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // memory port
   tkt_pkg::wr_en_type   wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [HASH_BITS-1:0] wr_hash;
   logic [KEY_BITS-1:0]  wr_key;
   logic [HASH_BITS-1:0] rd_hash;
   logic [KEY_BITS-1:0]  rd_key;

   logic                 issue;
   logic                 hit;
   logic [CNT_W-1:0]     dst_ptr;

   tkt_store #(
      .DEPTH     (ENTRIES),
      .ADDR_W    (IDX_W),
      .HASH_BITS (HASH_BITS),
      .KEY_BITS  (KEY_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_hash    (wr_hash),
      .wr_key     (wr_key),
      .rd_addr    (ptr_ff[IDX_W-1:0]),
      .rd_hash_ff (rd_hash),
      .rd_key_ff  (rd_key)
   );

   // A read is issued while the pointer is still inside the filled range;
   // the data of the previous issue is in rd_hash/rd_key when lag_vld_ff.
   assign issue   = (ptr_ff != count_ff);
   assign hit     = lag_vld_ff && (rd_hash == hash_ff);
   assign dst_ptr = lag_ptr_ff - 1'b1;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_slot  = rsp_slot_ff;
   assign rsp_chan.key_out     = rsp_key_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      lag_vld_in    = lag_vld_ff;
      lag_ptr_in    = lag_ptr_ff;
      func_in       = func_ff;
      hash_in       = hash_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = '0;
      wr_addr       = '0;
      wr_hash       = hash_ff;
      wr_key        = key_ff;

      // drop the response once it is taken
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in       = tkt_pkg::func_type'(req_chan.func);
               hash_in       = req_chan.lookup_hash[HASH_BITS-1:0];
               key_in        = req_chan.new_key[KEY_BITS-1:0];
               res_status_in = 1'b0;
               res_slot_in   = '0;
               res_key_in    = '0;
               ptr_in        = '0;
               lag_vld_in    = 1'b0;
               case (tkt_pkg::func_type'(req_chan.func))
                  tkt_pkg::FUNC_SET, tkt_pkg::FUNC_REMOVE: begin
                     state_in = ST_SEARCH;
                  end
                  tkt_pkg::FUNC_READ: begin
                     if (CMP_W'(req_chan.slot_index) < CMP_W'(count_ff)) begin
                        ptr_in   = CNT_W'(req_chan.slot_index);
                        state_in = ST_RD_WAIT;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  default: begin
                     // clear all
                     count_in = '0;
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            // advance the read pointer, compare the entry read last cycle
            lag_vld_in = issue;
            lag_ptr_in = ptr_ff;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (hit) begin
               res_slot_in = lag_ptr_ff[IDX_W-1:0];
               if (func_ff == tkt_pkg::FUNC_SET) begin
                  // overwrite the key in place
                  wr_en.key_we = 1'b1;
                  wr_addr      = lag_ptr_ff[IDX_W-1:0];
                  state_in     = ST_RESP;
               end else begin
                  // start moving later entries up from the one after the hit
                  ptr_in     = lag_ptr_ff + 1'b1;
                  lag_vld_in = 1'b0;
                  state_in   = ST_SHIFT;
               end
            end else if (!issue && !lag_vld_ff) begin
               if (func_ff == tkt_pkg::FUNC_SET && count_ff != CNT_W'(ENTRIES)) begin
                  // append at the end
                  wr_en.hash_we = 1'b1;
                  wr_en.key_we  = 1'b1;
                  wr_addr       = count_ff[IDX_W-1:0];
                  res_slot_in   = count_ff[IDX_W-1:0];
                  count_in      = count_ff + 1'b1;
               end else begin
                  // missing hash on remove, or table full on set
                  res_status_in = 1'b1;
               end
               state_in = ST_RESP;
            end
         end

         ST_SHIFT: begin
            lag_vld_in = issue;
            lag_ptr_in = ptr_ff;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (lag_vld_ff) begin
               wr_en.hash_we = 1'b1;
               wr_en.key_we  = 1'b1;
               wr_addr       = dst_ptr[IDX_W-1:0];
               wr_hash       = rd_hash;
               wr_key        = rd_key;
            end
            if (!issue && !lag_vld_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_RESP;
            end
         end

         ST_RD_WAIT: begin
            state_in = ST_RD_CAPT;
         end

         ST_RD_CAPT: begin
            res_key_in = rd_key;
            state_in   = ST_RESP;
         end

         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = tkt_pkg::SLOT_W'(res_slot_ff);
               rsp_key_in    = tkt_pkg::KEY_W'(res_key_ff);
               rsp_count_in  = tkt_pkg::COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         lag_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         lag_vld_ff   <= lag_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      hash_ff       <= hash_in;
      key_ff        <= key_in;
      lag_ptr_ff    <= lag_ptr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

// ----- test/tkt_table_checker.sv -----
// Response checker for the topic key table: tracks the table and compares every response.
`timescale 1ns / 1ps

module tkt_table_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire        clock,
   input  wire        reset,
   tkt_req_if         req_mon,
   tkt_rsp_if         rsp_mon,
   output int         fail_count,
   output int         outstanding,
   output int         table_fill
);

   typedef struct packed {
      logic                        status;
      logic [tkt_pkg::SLOT_W-1:0]  slot;
      logic [tkt_pkg::KEY_W-1:0]   key;
      logic [tkt_pkg::COUNT_W-1:0] count;
   } table_reply_type;

   logic [tkt_pkg::HASH_W-1:0] hash_mem [TABLE_DEPTH];
   logic [tkt_pkg::KEY_W-1:0]  key_mem  [TABLE_DEPTH];
   int                         fill_level;
   int                         errors;
   table_reply_type            replies_due [$];
   table_reply_type            due;

   // Position of a hash among the filled entries, or fill_level when absent.
   function automatic int find_hash(logic [tkt_pkg::HASH_W-1:0] h);
      for (int i = 0; i < fill_level; i++) begin
         if (hash_mem[i] == h) return i;
      end
      return fill_level;
   endfunction

   // Apply one request to the table copy and return the response it must produce.
   function automatic table_reply_type apply_request(tkt_pkg::func_type op,
                                                     logic [tkt_pkg::HASH_W-1:0] h,
                                                     logic [tkt_pkg::KEY_W-1:0] k,
                                                     logic [tkt_pkg::SLOT_W-1:0] idx);
      table_reply_type r;
      int              pos;
      r   = '0;
      pos = find_hash(h);
      case (op)
         tkt_pkg::FUNC_SET: begin
            if (pos < fill_level) begin
               key_mem[pos] = k;
               r.slot       = tkt_pkg::SLOT_W'(pos);
            end else if (fill_level >= TABLE_DEPTH) begin
               r.status = 1'b1;
            end else begin
               hash_mem[fill_level] = h;
               key_mem[fill_level]  = k;
               r.slot               = tkt_pkg::SLOT_W'(fill_level);
               fill_level++;
            end
         end
         tkt_pkg::FUNC_REMOVE: begin
            if (pos < fill_level) begin
               for (int j = pos + 1; j < fill_level; j++) begin
                  hash_mem[j-1] = hash_mem[j];
                  key_mem[j-1]  = key_mem[j];
               end
               fill_level--;
               r.slot = tkt_pkg::SLOT_W'(pos);
            end else begin
               r.status = 1'b1;
            end
         end
         tkt_pkg::FUNC_READ: begin
            if (int'(idx) < fill_level) r.key = key_mem[idx];
            else r.status = 1'b1;
         end
         default: begin
            fill_level = 0;
         end
      endcase
      r.count = tkt_pkg::COUNT_W'(fill_level);
      return r;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0d ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill_level = 0;
         errors     = 0;
         replies_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            replies_due.push_back(apply_request(tkt_pkg::func_type'(req_mon.func),
                                                req_mon.lookup_hash, req_mon.new_key,
                                                req_mon.slot_index));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replies_due.size() == 0) begin
               errors++;
               $display("%0d ns: response with none expected, actual status %b slot %0d",
                        $time, rsp_mon.status, rsp_mon.found_slot);
               $display("   key %h count %0d", rsp_mon.key_out, rsp_mon.entry_count);
            end else begin
               due = replies_due.pop_front();
               check_field("status", 64'(due.status), 64'(rsp_mon.status));
               check_field("found_slot", 64'(due.slot), 64'(rsp_mon.found_slot));
               check_field("key_out", 64'(due.key), 64'(rsp_mon.key_out));
               check_field("entry_count", 64'(due.count), 64'(rsp_mon.entry_count));
            end
         end
      end
      outstanding <= replies_due.size();
      table_fill  <= fill_level;
      fail_count  <= errors;
   end

endmodule

// ----- test/tb_topic_key_table_core.sv -----
// Testbench top for the topic key table: clock, reset, request traffic and the verdict.
`timescale 1ns / 1ps

module tb_topic_key_table_core;

   localparam int DEPTH       = 64;
   localparam int RANDOM_ITEMS = 1250;
   localparam int POOL_SIZE   = 96;
   // The worst case per item adds a sender gap, a full-table walk and
   // a receiver stall; the limit takes that several times over.
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 100;

   // Traffic mixes: grow the table toward full, churn it, or shrink it.
   typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} traffic_mix_type;

   localparam logic [tkt_pkg::HASH_W-1:0] H_ZERO = '0;
   localparam logic [tkt_pkg::HASH_W-1:0] H_ONES = '1;
   localparam logic [tkt_pkg::HASH_W-1:0] H_A    = 64'h5a5a_c3c3_0ff0_1234;
   localparam logic [tkt_pkg::HASH_W-1:0] H_B    = 64'ha5a5_3c3c_f00f_edcb;
   localparam logic [tkt_pkg::KEY_W-1:0]  K_ZERO = '0;
   localparam logic [tkt_pkg::KEY_W-1:0]  K_ONES = '1;

   logic clock;
   logic reset;

   int unsigned cycle_count = 0;
   int          fail_count;
   int          outstanding;
   int          table_fill;
   int          send_gap_max;
   int          rsp_stall_max;
   int          stall_left;
   int          items_sent;

   logic [tkt_pkg::HASH_W-1:0] hash_pool [POOL_SIZE];

   tkt_req_if req_chan ();
   tkt_rsp_if rsp_chan ();

   topic_key_table_core #(
      .ENTRIES   (DEPTH),
      .HASH_BITS (tkt_pkg::HASH_W),
      .KEY_BITS  (tkt_pkg::KEY_W)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tkt_table_checker #(
      .TABLE_DEPTH (DEPTH)
   ) table_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .table_fill  (table_fill)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: stop a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: after each taken response, drop ready for a freshly drawn
   // number of cycles; the countdown runs whether or not a response waits,
   // so stalls land on every phase of the block's work.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) stall_left = $urandom_range(0, rsp_stall_max);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Hold one item on the request channel until it is taken. Lower valid
   // only when a gap is drawn, so back-to-back items keep valid high.
   task automatic push_request(tkt_pkg::func_type op, logic [tkt_pkg::HASH_W-1:0] h,
                               logic [tkt_pkg::KEY_W-1:0] k,
                               logic [tkt_pkg::SLOT_W-1:0] idx);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= op;
      req_chan.lookup_hash <= h;
      req_chan.new_key     <= k;
      req_chan.slot_index  <= idx;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      items_sent++;
   endtask

   // Stop sending and hold until every response has come back.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic tkt_pkg::func_type pick_op(traffic_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (roll < 75) return tkt_pkg::FUNC_SET;
            if (roll < 85) return tkt_pkg::FUNC_REMOVE;
            return tkt_pkg::FUNC_READ;
         end
         MIX_CHURN: begin
            if (roll < 40) return tkt_pkg::FUNC_SET;
            if (roll < 74) return tkt_pkg::FUNC_REMOVE;
            if (roll < 96) return tkt_pkg::FUNC_READ;
            return tkt_pkg::FUNC_CLEAR;
         end
         default: begin
            if (roll < 15) return tkt_pkg::FUNC_SET;
            if (roll < 75) return tkt_pkg::FUNC_REMOVE;
            if (roll < 99) return tkt_pkg::FUNC_READ;
            return tkt_pkg::FUNC_CLEAR;
         end
      endcase
   endfunction

   // Send one random item: hashes come mostly from a shared pool so that sets
   // hit existing entries and removes find them; fresh hashes probe misses.
   task automatic push_random(traffic_mix_type mix);
      tkt_pkg::func_type          op;
      logic [tkt_pkg::HASH_W-1:0] h;
      logic [tkt_pkg::KEY_W-1:0]  k;
      logic [tkt_pkg::SLOT_W-1:0] idx;
      op = pick_op(mix);
      if ($urandom_range(0, 99) < 85) h = hash_pool[$urandom_range(0, POOL_SIZE - 1)];
      else h = random_word();
      case ($urandom_range(0, 19))
         0:       k = K_ZERO;
         1:       k = K_ONES;
         default: k = random_word();
      endcase
      if (table_fill > 0 && $urandom_range(0, 99) < 75)
         idx = tkt_pkg::SLOT_W'($urandom_range(0, table_fill - 1));
      else
         idx = tkt_pkg::SLOT_W'($urandom_range(0, 63));
      push_request(op, h, k, idx);
   endtask

   initial begin
      traffic_mix_type mix;
      int              phase_len;
      int              phase_num;

      // Hold reset and park every input at a known value.
      reset                = 1'b1;
      items_sent           = 0;
      send_gap_max         = 11;
      rsp_stall_max        = 11;
      req_chan.valid       = 1'b0;
      req_chan.func        = tkt_pkg::FUNC_SET;
      req_chan.lookup_hash = '0;
      req_chan.new_key     = '0;
      req_chan.slot_index  = '0;

      hash_pool[0] = H_ZERO;
      hash_pool[1] = H_ONES;
      for (int i = 2; i < POOL_SIZE; i++) hash_pool[i] = random_word();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table corners, append, overwrite, reads in and out of
      // range, remove from the middle, the end and the front, misses, clears.
      push_request(tkt_pkg::FUNC_CLEAR,  H_A,    K_ZERO, 6'd0);   // clear on an empty table
      push_request(tkt_pkg::FUNC_READ,   H_A,    K_ZERO, 6'd0);   // read on an empty table
      push_request(tkt_pkg::FUNC_REMOVE, H_A,    K_ZERO, 6'd0);   // remove on an empty table
      push_request(tkt_pkg::FUNC_SET,    H_ZERO, K_ONES, 6'd63);
      push_request(tkt_pkg::FUNC_SET,    H_ONES, K_ZERO, 6'd0);
      push_request(tkt_pkg::FUNC_SET,    H_A,    64'h0123_4567_89ab_cdef, 6'd0);
      push_request(tkt_pkg::FUNC_SET,    H_ZERO, 64'hfedc_ba98_7654_3210, 6'd0);  // overwrite
      push_request(tkt_pkg::FUNC_READ,   H_ZERO, K_ZERO, 6'd0);
      push_request(tkt_pkg::FUNC_READ,   H_ZERO, K_ZERO, 6'd2);
      push_request(tkt_pkg::FUNC_READ,   H_ZERO, K_ZERO, 6'd3);   // index equal to the count
      push_request(tkt_pkg::FUNC_READ,   H_ZERO, K_ONES, 6'd63);  // index far out of range
      push_request(tkt_pkg::FUNC_REMOVE, H_ONES, K_ZERO, 6'd0);   // middle entry, shift up
      push_request(tkt_pkg::FUNC_READ,   H_ONES, K_ZERO, 6'd1);
      push_request(tkt_pkg::FUNC_REMOVE, H_B,    K_ZERO, 6'd0);   // missing hash
      push_request(tkt_pkg::FUNC_REMOVE, H_A,    K_ZERO, 6'd0);   // last entry
      push_request(tkt_pkg::FUNC_REMOVE, H_ZERO, K_ZERO, 6'd0);   // first and only entry
      push_request(tkt_pkg::FUNC_SET,    H_B,    K_ONES, 6'd0);
      push_request(tkt_pkg::FUNC_SET,    H_A,    K_ZERO, 6'd0);
      push_request(tkt_pkg::FUNC_CLEAR,  H_ZERO, K_ONES, 6'd63);  // clear a filled table
      push_request(tkt_pkg::FUNC_READ,   H_B,    K_ZERO, 6'd0);
      push_request(tkt_pkg::FUNC_SET,    H_A,    64'h8000_0000_0000_0001, 6'd0);
      push_request(tkt_pkg::FUNC_CLEAR,  H_A,    K_ZERO, 6'd0);
      drain_responses();

      // Random phases. Open with growth so the table reaches full early;
      // vary idling per phase, with some phases running flat out.
      items_sent = 0;
      phase_num  = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (phase_num == 0) mix = MIX_GROW;
         else mix = traffic_mix_type'($urandom_range(0, 2));
         phase_len     = (mix == MIX_GROW) ? $urandom_range(120, 200) : $urandom_range(40, 140);
         send_gap_max  = ($urandom_range(0, 9) < 3) ? 0 : 11;
         rsp_stall_max = ($urandom_range(0, 9) < 3) ? 0 : 11;
         for (int n = 0; n < phase_len && items_sent < RANDOM_ITEMS; n++) push_random(mix);
         // Let the table settle between phases.
         drain_responses();
         phase_num++;
      end

      // Allow for any stray response after the last expected one.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/tkt_pkg.sv
src/tkt_req_if.sv
src/tkt_rsp_if.sv
src/tkt_store.sv
src/topic_key_table_core.sv
test/tkt_table_checker.sv
test/tb_topic_key_table_core.sv
